// ===== src/uflr_pkg.sv =====
// ----------------------------------------------------------------------------
// uflr_pkg
// Shared types and constants of the line and frame receiver.
// ----------------------------------------------------------------------------
package uflr_pkg;

	// buffer geometry
	localparam int BUFFER_DEPTH = 64;
	localparam int IDX_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

	// special characters
	localparam logic [7:0] CHAR_CR          = 8'h0D;
	localparam logic [7:0] CHAR_LF          = 8'h0A;
	localparam logic [7:0] START_CHAR_RESET = 8'h24;
	localparam logic [7:0] END_CHAR_RESET   = 8'h23;

	// register map indexes
	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	// output kinds
	localparam logic KIND_LINE  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef enum logic [1:0] {
		FUNC_BYTE  = 2'd0,
		FUNC_LINE  = 2'd1,
		FUNC_FRAME = 2'd2,
		FUNC_IDLE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_FRAME = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_RD    = 2'd1,
		ST_LOAD  = 2'd2,
		ST_EMPTY = 2'd3
	} st_t;

	// delimiter configuration
	typedef struct packed {
		logic [7:0] start_char;
		logic [7:0] end_char;
	} cfg_t;

endpackage

// ===== src/uflr_ram.sv =====
// ----------------------------------------------------------------------------
// uflr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module uflr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/uflr_ctrl.sv =====
// ----------------------------------------------------------------------------
// uflr_ctrl
// Capture control, buffer sequencer and output register of the receiver.
// ----------------------------------------------------------------------------
module uflr_ctrl
	import uflr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic [1:0]       s_tuser,   // [1:0] func
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast,
	output logic [1:0]       m_tuser,   // [0] kind, [1] empty_res
	// buffer ram
	output logic             ram_we,
	output logic [IDX_W-1:0] ram_waddr,
	output logic [7:0]       ram_wdata,
	output logic             ram_re,
	output logic [IDX_W-1:0] ram_raddr,
	input  logic [7:0]       ram_rdata
);

	st_t              state_q, state_d;
	mode_t            mode_q, mode_d;
	logic             cr_q, cr_d;
	logic             in_frame_q, in_frame_d;
	logic [CNT_W-1:0] fill_q, fill_d;

	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] len_q;
	logic             kind_q;

	logic             m_valid_q;
	logic [7:0]       m_byte_q;
	logic             m_last_q;
	logic             m_kind_q;
	logic             m_empty_q;

	logic             acc;
	func_t            func;
	logic [7:0]       b;
	logic             start_drain;
	logic             drain_kind;
	logic             emit_empty;
	logic             out_free;
	logic             rd_last;
	logic             load_out;
	logic             load_empty;

	assign func     = func_t'(s_tuser);
	assign b        = s_tdata;
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign rd_last  = (CNT_W'(rd_idx_q) + CNT_W'(1)) == len_q;

	// decode one accepted word against the capture state
	always_comb begin
		mode_d      = mode_q;
		cr_d        = cr_q;
		in_frame_d  = in_frame_q;
		fill_d      = fill_q;
		ram_we      = 1'b0;
		ram_waddr   = fill_q[IDX_W-1:0];
		ram_wdata   = b;
		start_drain = 1'b0;
		drain_kind  = KIND_LINE;
		emit_empty  = 1'b0;
		if (acc) begin
			if (func != FUNC_BYTE) begin
				cr_d       = 1'b0;
				in_frame_d = 1'b0;
				fill_d     = '0;
				unique case (func)
					FUNC_LINE:  mode_d = MODE_LINE;
					FUNC_FRAME: mode_d = MODE_FRAME;
					default:    mode_d = MODE_IDLE;
				endcase
			end else if (mode_q == MODE_LINE) begin
				cr_d = cr_q || (b == CHAR_CR);
				if (cr_d && (b == CHAR_LF)) begin
					start_drain = (fill_q != '0);
					drain_kind  = KIND_LINE;
					cr_d        = 1'b0;
					in_frame_d  = 1'b0;
					fill_d      = '0;
					mode_d      = MODE_IDLE;
				end else if (fill_q < CNT_W'(BUFFER_DEPTH)) begin
					ram_we = 1'b1;
					fill_d = fill_q + CNT_W'(1);
				end
			end else if (mode_q == MODE_FRAME) begin
				priority if (!in_frame_q) begin
					if (b == cfg.start_char) begin
						in_frame_d = 1'b1;
						fill_d     = '0;
					end
				end else if (b == cfg.end_char) begin
					start_drain = (fill_q != '0);
					emit_empty  = (fill_q == '0);
					drain_kind  = KIND_FRAME;
					cr_d        = 1'b0;
					in_frame_d  = 1'b0;
					fill_d      = '0;
				end else if (b == cfg.start_char) begin
					cr_d       = 1'b0;
					in_frame_d = 1'b0;
					fill_d     = '0;
				end else if (fill_q < CNT_W'(BUFFER_DEPTH)) begin
					ram_we = 1'b1;
					fill_d = fill_q + CNT_W'(1);
				end else begin
					cr_d       = 1'b0;
					in_frame_d = 1'b0;
					fill_d     = '0;
				end
			end
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_drain) begin
					state_d = ST_RD;
				end else if (emit_empty) begin
					state_d = ST_EMPTY;
				end
			end
			ST_RD:    state_d = ST_LOAD;
			ST_LOAD: begin
				if (out_free) begin
					state_d = rd_last ? ST_IDLE : ST_RD;
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ram_re     = (state_q == ST_RD);
		ram_raddr  = rd_idx_q;
		load_out   = (state_q == ST_LOAD) && out_free;
		load_empty = (state_q == ST_EMPTY) && out_free;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_IDLE;
			cr_q       <= 1'b0;
			in_frame_q <= 1'b0;
			fill_q     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			cr_q       <= cr_d;
			in_frame_q <= in_frame_d;
			fill_q     <= fill_d;
			if (load_out || load_empty) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// drain pointer and release length
	always_ff @(posedge clk) begin
		if (start_drain) begin
			rd_idx_q <= '0;
			len_q    <= fill_q;
			kind_q   <= drain_kind;
		end else if (load_out) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_byte_q  <= ram_rdata;
			m_last_q  <= rd_last;
			m_kind_q  <= kind_q;
			m_empty_q <= 1'b0;
		end else if (load_empty) begin
			m_byte_q  <= 8'h00;
			m_last_q  <= 1'b1;
			m_kind_q  <= KIND_FRAME;
			m_empty_q <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_empty_q, m_kind_q};

	// buffer never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(BUFFER_DEPTH))
		else $error("fill count beyond buffer depth");

	// no buffer write while a release is draining
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !ram_we)
		else $error("buffer write during drain");

	// a mode command empties the capture
	a_cmd_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (func != FUNC_BYTE)) |=> (fill_q == '0) && !cr_q && !in_frame_q)
		else $error("mode command left capture state");

	// an empty-frame word is a lone final frame word with zero data
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_empty_q) |-> (m_last_q && m_kind_q && (m_byte_q == 8'h00)))
		else $error("malformed empty-frame word");

endmodule

// ===== src/uart_line_and_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// uart_line_and_frame_receiver_core
// Reply-line and delimited-frame receiver with a byte buffer and APB setup.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while no release is running.
// A release passes each buffered byte through the buffer read port (read,
// then load the output register); input is held off meanwhile.
// Reset: control state clears at once, delimiters return to '$' and '#';
// buffer contents are not cleared, entries are read only after being written.
module uart_line_and_frame_receiver_core
	import uflr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] func
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // [0] kind, [1] empty_res
);

	cfg_t             cfg_q;
	logic             cfg_wr;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// delimiter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char <= START_CHAR_RESET;
			cfg_q.end_char   <= END_CHAR_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_START: cfg_q.start_char <= pwdata[7:0];
				REG_END:   cfg_q.end_char   <= pwdata[7:0];
				default:   ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_START: prdata = {24'h0, cfg_q.start_char};
			REG_END:   prdata = {24'h0, cfg_q.end_char};
			default:   prdata = 32'h0;
		endcase
	end

	uflr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	uflr_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
